// ----- hw/rtl/interpolated_wavetable_oscillator_macros.svh -----
// Assertion macros for the interpolated wavetable oscillator.
// Included by the top level; no other dependencies.
`ifndef INTERPOLATED_WAVETABLE_OSCILLATOR_MACROS_SVH
`define INTERPOLATED_WAVETABLE_OSCILLATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define IWO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define IWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/iwo_pkg.sv -----
// Shared constants, types and codes of the interpolated wavetable oscillator.
// No dependencies; used by the top level and iwo_mod_unit.
package iwo_pkg;

    // Table depth must be a power of two.
    localparam int TABLE_DEPTH = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int RES_FRAC    = 24;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int SIZE_W  = ADDR_W + 1;

    localparam int CMD_W   = 2;
    localparam int FREQ_W  = 35;
    localparam int PHASE_W = 18;
    localparam int TADDR_W = 12;
    localparam int RATE_W  = 18;
    localparam int RES_W   = 25;
    localparam int TSIZE_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RES_W;

    localparam int IN_FIELDS_W = FREQ_W + PHASE_W + TADDR_W + SAMPLE_BITS;
    localparam int S_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int PHASE_LSB = FREQ_W;
    localparam int TADDR_LSB = PHASE_LSB + PHASE_W;
    localparam int TVAL_LSB  = TADDR_LSB + TADDR_W;

    localparam int POS_W   = RATE_W + FRAC_BITS;
    localparam int PROD_W  = PHASE_W + RATE_W + 1;
    localparam int X_W     = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;
    localparam int NUM_W   = X_W - 1;
    localparam int DEN_W   = POS_W;
    localparam int T_W     = POS_W + RES_W;
    localparam int IDXF_LSB = FRAC_BITS + RES_FRAC;
    localparam int IDXF_W  = T_W - IDXF_LSB;
    localparam int P_LO_W  = POS_W / 2;
    localparam int P_HI_W  = POS_W - P_LO_W;
    localparam int MLO_W   = P_LO_W + RES_W;
    localparam int MHI_W   = P_HI_W + RES_W;
    localparam int IP_W    = SAMPLE_BITS + FRAC_BITS + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_REWIND = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE = 2'd0,
        CFG_RES  = 2'd1,
        CFG_SIZE = 2'd2
    } cfg_idx_t;

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
    localparam logic [RES_W-1:0]   RES_RESET  = RES_W'(1431655);
    localparam logic [TSIZE_W-1:0] SIZE_RESET = TSIZE_W'(4096);

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_MUL,
        S_P_ADD,
        S_P_DIV,
        S_P_WAIT,
        S_T_LO,
        S_T_HI,
        S_T_SUM,
        S_I_DIV,
        S_I_WAIT,
        S_RD_A,
        S_RD_B,
        S_I_MUL,
        S_I_ADD,
        S_Q_ADD,
        S_Q_DIV,
        S_Q_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DEN_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ----- hw/rtl/iwo_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/iwo_mod_unit.sv -----
// Bit-serial floor-modulo unit: one restoring step per cycle.
// Depends on iwo_pkg for widths and the request/response structs.
module iwo_mod_unit
    import iwo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic             neg_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = DEN_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.mag;
            den_reg <= req.den;
            neg_reg <= req.neg;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Fold a negative dividend back into [0, den).
    always_comb
    begin
        rsp.done = done_reg;
        rsp.busy = busy_reg;
        if (neg_reg && (rem_reg != '0))
        begin
            rsp.rem = den_reg - rem_reg;
        end
        else
        begin
            rsp.rem = rem_reg;
        end
    end

endmodule

// ----- hw/rtl/interpolated_wavetable_oscillator.sv -----
// Top level of the interpolated wavetable oscillator: sequencer, datapath, table RAM.
// Depends on iwo_pkg, iwo_ram, iwo_mod_unit and the assertion macro header.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | tuser: command; tdata: item fields
//  m_*     | out       | m_tvalid/m_tready  | tdata: sample_out
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Write and rewind transactions are taken without leaving the idle state; an unused command is dropped.
// A sample result is loaded after three passes through the bit-serial remainder unit and
// two reads of the table RAM; the next item is taken in the cycle after it is loaded.
// The finished sample waits in an output register; a new item is taken meanwhile,
// and a later sample stalls only if that register is still full.
// Reset clears the position and loads the register defaults; the table is unset.
`include "interpolated_wavetable_oscillator_macros.svh"

module interpolated_wavetable_oscillator
    import iwo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [34:0] frequency, [52:35] phase_offset, [64:53] table_address,
    // [80:65] table_value, rest zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] sample_out
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [RATE_W-1:0]  rate_reg;
    logic [RES_W-1:0]   res_reg;
    logic [TSIZE_W-1:0] size_reg;
    logic [POS_W-1:0]   position_reg;
    logic               m_valid_reg;

    logic [FREQ_W-1:0]      freq_reg;
    logic [PHASE_W-1:0]     ph_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [X_W-1:0]  fcl_reg;
    logic signed [X_W-1:0]  x_reg;
    logic [POS_W-1:0]       p_reg;
    logic [MLO_W-1:0]       mlo_reg;
    logic [MHI_W-1:0]       mhi_reg;
    logic [T_W-1:0]         t_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [IP_W-1:0] iprod_reg;
    logic [SAMPLE_BITS-1:0] y_reg;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic               s_accept;
    cmd_t               s_cmd;
    logic [RATE_W-1:0]  rate_eff;
    logic [POS_W-1:0]   big_r;
    logic [SIZE_W-1:0]  size_eff;
    logic [ADDR_W-1:0]  nxt_idx;
    logic [SIZE_W-1:0]  idx_inc;
    logic signed [X_W-1:0] fx;
    logic signed [X_W-1:0] rx;
    logic signed [X_W-1:0] fcl_next;
    logic signed [PROD_W-1:0] prod_next;
    logic [X_W-1:0]     x_mag;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [IP_W-1:0] iprod_next;
    logic signed [IP_W-1:0] y_sum;
    logic               out_free;

    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign s_accept  = s_tvalid && s_tready;
    assign s_cmd     = cmd_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_DATA_W'(out_reg);
    assign out_free  = !m_valid_reg || m_tready;

    // Effective register values.
    always_comb
    begin
        rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
        big_r    = {rate_eff, {FRAC_BITS{1'b0}}};
        if (size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (32'(size_reg) > 32'(TABLE_DEPTH))
        begin
            size_eff = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size_eff = SIZE_W'(size_reg);
        end
    end

    // Datapath arithmetic.
    always_comb
    begin
        prod_next = $signed(ph_reg) * $signed({1'b0, rate_eff});
        fx = {{(X_W-FREQ_W){freq_reg[FREQ_W-1]}}, freq_reg};
        rx = $signed({{(X_W-POS_W){1'b0}}, big_r});
        if (fx > rx)
        begin
            fcl_next = rx;
        end
        else if (fx < -rx)
        begin
            fcl_next = -rx;
        end
        else
        begin
            fcl_next = fx;
        end
        x_mag   = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
        idx_inc = SIZE_W'(idx_reg) + SIZE_W'(1);
        nxt_idx = (idx_inc == size_eff) ? '0 : ADDR_W'(idx_inc);
        diff    = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata})
                - $signed({a_reg[SAMPLE_BITS-1], a_reg});
        iprod_next = $signed({{(IP_W-SAMPLE_BITS-1){diff[SAMPLE_BITS]}}, diff})
                   * $signed({{(IP_W-FRAC_BITS){1'b0}}, t_reg[IDXF_LSB-1:RES_FRAC]});
        y_sum = $signed({{(IP_W-SAMPLE_BITS){a_reg[SAMPLE_BITS-1]}}, a_reg})
              + (iprod_reg >>> FRAC_BITS);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_cmd == CMD_SAMPLE))
                begin
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL:  state_next = S_P_ADD;
            S_P_ADD:  state_next = S_P_DIV;
            S_P_DIV:  state_next = S_P_WAIT;
            S_P_WAIT: state_next = mod_rsp.done ? S_T_LO : S_P_WAIT;
            S_T_LO:   state_next = S_T_HI;
            S_T_HI:   state_next = S_T_SUM;
            S_T_SUM:  state_next = S_I_DIV;
            S_I_DIV:  state_next = S_I_WAIT;
            S_I_WAIT: state_next = mod_rsp.done ? S_RD_A : S_I_WAIT;
            S_RD_A:   state_next = S_RD_B;
            S_RD_B:   state_next = S_I_MUL;
            S_I_MUL:  state_next = S_I_ADD;
            S_I_ADD:  state_next = S_Q_ADD;
            S_Q_ADD:  state_next = S_Q_DIV;
            S_Q_DIV:  state_next = S_Q_WAIT;
            S_Q_WAIT: state_next = mod_rsp.done ? S_OUT : S_Q_WAIT;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready      = 1'b0;
        mod_req.start = 1'b0;
        mod_req.neg   = x_reg[X_W-1];
        mod_req.mag   = NUM_W'(x_mag);
        mod_req.den   = big_r;
        ram_raddr     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_P_DIV, S_Q_DIV:
            begin
                mod_req.start = 1'b1;
            end
            S_I_DIV:
            begin
                mod_req.start = 1'b1;
                mod_req.neg   = 1'b0;
                mod_req.mag   = NUM_W'(t_reg[T_W-1:IDXF_LSB]);
                mod_req.den   = DEN_W'(size_eff);
            end
            S_RD_B:
            begin
                ram_raddr = nxt_idx;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign ram_we    = s_accept && (s_cmd == CMD_WRITE);
    assign ram_waddr = ADDR_W'(s_tdata[TADDR_LSB +: TADDR_W]);

    iwo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[TVAL_LSB +: SAMPLE_BITS]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    iwo_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Control state, configuration and position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rate_reg     <= RATE_RESET;
            res_reg      <= RES_RESET;
            size_reg     <= SIZE_RESET;
            position_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                    CFG_RES:  res_reg  <= cfg_data[RES_W-1:0];
                    CFG_SIZE: size_reg <= cfg_data[TSIZE_W-1:0];
                    default:  rate_reg <= rate_reg;
                endcase
            end
            if (s_accept && (s_cmd == CMD_REWIND))
            begin
                position_reg <= '0;
            end
            else if ((state_reg == S_Q_WAIT) && mod_rsp.done)
            begin
                position_reg <= mod_rsp.rem;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    freq_reg <= s_tdata[FREQ_W-1:0];
                    ph_reg   <= s_tdata[PHASE_LSB +: PHASE_W];
                end
            end
            S_P_MUL:
            begin
                prod_reg <= prod_next;
                fcl_reg  <= fcl_next;
            end
            S_P_ADD:
            begin
                x_reg <= $signed({{(X_W-POS_W){1'b0}}, position_reg})
                       + {{(X_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            S_P_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    p_reg <= mod_rsp.rem;
                end
            end
            S_T_LO:
            begin
                mlo_reg <= p_reg[P_LO_W-1:0] * res_reg;
            end
            S_T_HI:
            begin
                mhi_reg <= p_reg[POS_W-1:P_LO_W] * res_reg;
            end
            S_T_SUM:
            begin
                t_reg <= {mhi_reg, {P_LO_W{1'b0}}} + T_W'(mlo_reg);
            end
            S_I_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    idx_reg <= ADDR_W'(mod_rsp.rem);
                end
            end
            S_RD_B:
            begin
                a_reg <= ram_rdata;
            end
            S_I_MUL:
            begin
                iprod_reg <= iprod_next;
            end
            S_I_ADD:
            begin
                y_reg <= SAMPLE_BITS'(y_sum);
            end
            S_Q_ADD:
            begin
                x_reg <= $signed({{(X_W-POS_W){1'b0}}, position_reg}) + fcl_reg;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= y_reg;
                end
            end
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
    end

    `IWO_ASSERT_NOW(a_done_in_wait, clk, rst_n, mod_rsp.done,
        (state_reg == S_P_WAIT) || (state_reg == S_I_WAIT) || (state_reg == S_Q_WAIT),
        "remainder finished outside a wait state")

    `IWO_ASSERT_NOW(a_idx_in_size, clk, rst_n, state_reg == S_RD_A,
        SIZE_W'(idx_reg) < size_eff, "table index beyond table size")

    `IWO_ASSERT_NOW(a_idle_unit, clk, rst_n, state_reg == S_IDLE,
        !mod_rsp.busy, "remainder unit busy while sequencer idle")

    `IWO_ASSERT_NEXT(a_out_load, clk, rst_n, (state_reg == S_OUT) && out_free,
        m_tvalid && (m_tdata[SAMPLE_BITS-1:0] == $past(y_reg)),
        "finished sample not presented")

endmodule
